[rtl/lcfr_pkg.sv]
// Shared constants for the line and circle frame rasterizer.
// Field widths, command codes and arithmetic widths; no dependencies.
package lcfr_pkg;

    // Field widths of the command and result beats
    localparam int CMD_W = 2;
    localparam int X_W   = 7;
    localparam int Y_W   = 6;
    localparam int R_W   = 6;

    // Default frame size
    localparam int DEF_BOARD_WIDTH  = 80;
    localparam int DEF_BOARD_HEIGHT = 40;

    // Signed plot coordinate: center plus or minus a doubled radius
    localparam int C_W = X_W + 2;
    // Signed error terms of the line and circle walks
    localparam int D_W = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

endpackage

[rtl/line_circle_frame_rasterizer_top.sv]
// Line and circle rasterizer over a one-bit frame store, with one shared plot path.
// Depends on lcfr_pkg.
//
//   channel   direction  handshake                  payload
//   command   in         start & !busy              i_command, i_first_x, i_first_y,
//                                                   i_second_x, i_second_y, i_circle_radius
//   result    out        o_result_valid, 1 cycle    o_pixel_value, o_bad_operand
//
// One command at a time; busy is high from accepting a legal command until the result cycle.
// Clear: one frame bit per cycle through the write port, with busy high throughout.
// Line: one plotted pixel per walk step, then a closing step. Circle: eight plots per
// octant point, one per reflection. Read: an address state, then a data state. A rejected
// command returns its beat in the next cycle. After reset the same clearing pass runs
// with busy high. Results cannot be stalled: each is on the ports for exactly one cycle.
module line_circle_frame_rasterizer_top
    import lcfr_pkg::*;
#(
    parameter int BOARD_WIDTH  = DEF_BOARD_WIDTH,
    parameter int BOARD_HEIGHT = DEF_BOARD_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] i_command,
    input  logic [X_W-1:0]   i_first_x,
    input  logic [Y_W-1:0]   i_first_y,
    input  logic [X_W-1:0]   i_second_x,
    input  logic [Y_W-1:0]   i_second_y,
    input  logic [R_W-1:0]   i_circle_radius,
    output logic             o_result_valid,
    output logic             o_pixel_value,
    output logic             o_bad_operand
);

    localparam int N_PIX = BOARD_WIDTH * BOARD_HEIGHT;
    localparam int AW    = $clog2(N_PIX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LINE,
        S_CIRC,
        S_READ_A,
        S_READ_D
    } t_state;

    t_state r_state;
    logic   r_init;
    logic   r_res_vld;
    logic   r_pix;
    logic   r_bad;

    logic [AW-1:0] r_clr_addr;

    // Walk registers: current point / center, line end, error terms
    logic [X_W-1:0]        r_ax;
    logic [Y_W-1:0]        r_ay;
    logic [X_W-1:0]        r_bx;
    logic [Y_W-1:0]        r_by;
    logic [X_W-1:0]        r_adx;
    logic [Y_W-1:0]        r_ady;
    logic                  r_sxn;
    logic                  r_syn;
    logic signed [D_W-1:0] r_acc;
    logic [R_W-1:0]        r_u;
    logic [R_W-1:0]        r_v;
    logic [2:0]            r_ph;

    // Plot stage between the sequencer and the store
    logic           r_wr_vld;
    logic [C_W-2:0] r_wx;
    logic [C_W-2:0] r_wy;

    logic          r_mem [0:N_PIX-1];
    logic          r_rd_bit;

    // Accept-time operand checks
    logic          acc_cmd;
    logic          first_ok;
    logic          second_ok;
    logic          rad_ok;
    logic          cmd_bad;
    logic [X_W-1:0] adx_in;
    logic [Y_W-1:0] ady_in;

    // Line step
    logic signed [D_W-1:0] adx_s;
    logic signed [D_W-1:0] ady_s;
    logic signed [D_W-1:0] twice;
    logic                  x_go;
    logic                  y_go;
    logic signed [D_W-1:0] n_acc;
    logic                  line_end;

    // Circle step
    logic [R_W-1:0]        u1;
    logic signed [D_W-1:0] u1_s;
    logic signed [D_W-1:0] v1_s;
    logic signed [D_W-1:0] n_dec;
    logic [R_W-1:0]        off_x;
    logic [R_W-1:0]        off_y;
    logic signed [C_W-1:0] xoff;
    logic signed [C_W-1:0] yoff;
    logic signed [C_W-1:0] cx_s;
    logic signed [C_W-1:0] cy_s;

    // Plot point from the sequencer
    logic                  pt_vld;
    logic signed [C_W-1:0] pt_x;
    logic signed [C_W-1:0] pt_y;
    logic                  pt_in;

    // Store port
    logic          wr_en;
    logic          wr_bit;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign busy           = (r_state != S_IDLE);
    assign acc_cmd        = start && !busy;
    assign o_result_valid = r_res_vld;
    assign o_pixel_value  = r_pix;
    assign o_bad_operand  = r_bad;

    // Check operands of the incoming command
    assign first_ok  = (32'(i_first_x) < BOARD_WIDTH) && (32'(i_first_y) < BOARD_HEIGHT);
    assign second_ok = (32'(i_second_x) < BOARD_WIDTH) && (32'(i_second_y) < BOARD_HEIGHT);
    assign rad_ok    = (32'(i_circle_radius) <= BOARD_WIDTH)
                    && (32'(i_circle_radius) <= BOARD_HEIGHT);
    assign adx_in    = (i_second_x > i_first_x) ? i_second_x - i_first_x
                                                : i_first_x - i_second_x;
    assign ady_in    = (i_second_y > i_first_y) ? i_second_y - i_first_y
                                                : i_first_y - i_second_y;

    // Flag a command whose operands fall outside the frame
    always_comb begin
        case (i_command)
            CMD_LINE:   cmd_bad = !(first_ok && second_ok);
            CMD_CIRCLE: cmd_bad = !(first_ok && rad_ok);
            CMD_READ:   cmd_bad = !first_ok;
            default:    cmd_bad = 1'b0;
        endcase
    end

    // Bresenham step: one error update per plotted pixel
    always_comb begin
        adx_s    = D_W'(r_adx);
        ady_s    = D_W'(r_ady);
        twice    = r_acc <<< 1;
        x_go     = (twice >= -ady_s);
        y_go     = (twice <= adx_s);
        n_acc    = r_acc + (x_go ? -ady_s : '0) + (y_go ? adx_s : '0);
        line_end = (r_ax == r_bx) && (r_ay == r_by);
    end

    // Midpoint circle step, taken after the eighth plot of each octant point
    always_comb begin
        u1    = r_u + R_W'(1);
        u1_s  = D_W'(u1);
        v1_s  = D_W'(r_v - R_W'(1));
        n_dec = r_acc[D_W-1] ? r_acc + (u1_s <<< 1) + D_W'(1)
                             : r_acc + ((u1_s - v1_s) <<< 1) + D_W'(1);
    end

    // Pick the plot point: line walk or one of eight circle reflections
    always_comb begin
        off_x = r_ph[2] ? r_v : r_u;
        off_y = r_ph[2] ? r_u : r_v;
        xoff  = C_W'({off_x, 1'b0});
        yoff  = C_W'(off_y);
        cx_s  = C_W'(r_ax);
        cy_s  = C_W'(r_ay);
        pt_vld = 1'b0;
        pt_x   = cx_s;
        pt_y   = cy_s;
        case (r_state)
            S_LINE: begin
                pt_vld = !line_end;
            end
            S_CIRC: begin
                pt_vld = 1'b1;
                pt_x   = r_ph[0] ? cx_s - xoff : cx_s + xoff;
                pt_y   = r_ph[1] ? cy_s - yoff : cy_s + yoff;
            end
            default: begin
                pt_vld = 1'b0;
            end
        endcase
        pt_in = !pt_x[C_W-1] && !pt_y[C_W-1]
             && (32'(pt_x[C_W-2:0]) < BOARD_WIDTH)
             && (32'(pt_y[C_W-2:0]) < BOARD_HEIGHT);
    end

    // Store port: clearing sweep or a clipped plot
    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_bit  = 1'b0;
            wr_addr = r_clr_addr;
        end else begin
            wr_en   = r_wr_vld;
            wr_bit  = 1'b1;
            wr_addr = AW'(32'(r_wy) * BOARD_WIDTH + 32'(r_wx));
        end
        rd_addr = AW'(32'(r_ay) * BOARD_WIDTH + 32'(r_ax));
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_bit;
        end
        if (r_state == S_READ_A) begin
            r_rd_bit <= r_mem[rd_addr];
        end
    end

    // Plot stage: hold the clipped point for the address multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= pt_vld && pt_in;
        end
        r_wx <= pt_x[C_W-2:0];
        r_wy <= pt_y[C_W-2:0];
    end

    // Sequencer: state and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_init     <= 1'b1;
            r_clr_addr <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // A rejected command answers at once and stays idle
                    r_res_vld <= acc_cmd && cmd_bad;
                    if (acc_cmd) begin
                        r_pix <= 1'b0;
                        r_bad <= cmd_bad;
                        r_ax  <= i_first_x;
                        r_ay  <= i_first_y;
                        case (i_command)
                            CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            CMD_LINE: begin
                                if (!cmd_bad) begin
                                    r_bx    <= i_second_x;
                                    r_by    <= i_second_y;
                                    r_adx   <= adx_in;
                                    r_ady   <= ady_in;
                                    r_sxn   <= !(i_first_x < i_second_x);
                                    r_syn   <= !(i_first_y < i_second_y);
                                    r_acc   <= D_W'(adx_in) - D_W'(ady_in);
                                    r_state <= S_LINE;
                                end
                            end
                            CMD_CIRCLE: begin
                                if (!cmd_bad) begin
                                    r_u     <= '0;
                                    r_v     <= i_circle_radius;
                                    r_ph    <= '0;
                                    r_acc   <= D_W'(1) - D_W'(i_circle_radius);
                                    r_state <= S_CIRC;
                                end
                            end
                            CMD_READ: begin
                                if (!cmd_bad) begin
                                    r_state <= S_READ_A;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    r_res_vld  <= (r_clr_addr == AW'(N_PIX - 1)) && !r_init;
                    if (r_clr_addr == AW'(N_PIX - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_LINE: begin
                    r_res_vld <= line_end;
                    if (line_end) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_acc <= n_acc;
                        if (x_go) begin
                            r_ax <= r_sxn ? r_ax - X_W'(1) : r_ax + X_W'(1);
                        end
                        if (y_go) begin
                            r_ay <= r_syn ? r_ay - Y_W'(1) : r_ay + Y_W'(1);
                        end
                    end
                end
                S_CIRC: begin
                    r_ph      <= r_ph + 3'd1;
                    r_res_vld <= (r_ph == 3'd7) && !(r_v > r_u);
                    if (r_ph == 3'd7) begin
                        if (r_v > r_u) begin
                            r_u   <= u1;
                            r_acc <= n_dec;
                            if (!r_acc[D_W-1]) begin
                                r_v <= r_v - R_W'(1);
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ_A: begin
                    r_res_vld <= 1'b0;
                    r_state   <= S_READ_D;
                end
                S_READ_D: begin
                    r_pix     <= r_rd_bit;
                    r_res_vld <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_res_vld <= 1'b0;
                    r_state   <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sim/tb_line_circle_frame_rasterizer_top.sv]
// Self-checking testbench for the line and circle frame rasterizer: directed table, then
// bursty random drawing commands checked against an in-bench frame predictor.
// Depends on lcfr_pkg and line_circle_frame_rasterizer_top.
`timescale 1ns / 1ps

module tb_line_circle_frame_rasterizer_top;
    import lcfr_pkg::*;

    localparam int FRAME_W      = DEF_BOARD_WIDTH;
    localparam int FRAME_H      = DEF_BOARD_HEIGHT;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_EVERY  = 350;
    localparam int TIMEOUT_NS   = 8_000_000;
    localparam bit FROM_MODEL   = 1'b0;
    localparam bit TYPED        = 1'b1;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [X_W-1:0]   fx;
        logic [Y_W-1:0]   fy;
        logic [X_W-1:0]   sx;
        logic [Y_W-1:0]   sy;
        logic [R_W-1:0]   rad;
    } t_draw_cmd;

    typedef struct {
        bit pixel;
        bit bad;
    } t_draw_result;

    typedef struct {
        t_draw_cmd    c;
        bit           typed;
        t_draw_result res;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] i_command = CMD_CLEAR;
    logic [X_W-1:0]   i_first_x = '0;
    logic [Y_W-1:0]   i_first_y = '0;
    logic [X_W-1:0]   i_second_x = '0;
    logic [Y_W-1:0]   i_second_y = '0;
    logic [R_W-1:0]   i_circle_radius = '0;
    logic             o_result_valid;
    logic             o_pixel_value;
    logic             o_bad_operand;

    // Predicted frame contents and the results still owed by the block
    bit           frame_bits [FRAME_H][FRAME_W];
    int           last_px;
    int           last_py;
    t_draw_result owed_results[$];
    t_plan_row    plan[$];

    int err_count;
    int cnt_clear, cnt_line, cnt_circle, cnt_read, cnt_read_set, cnt_bad;

    line_circle_frame_rasterizer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_circle_radius (i_circle_radius),
        .o_result_valid  (o_result_valid),
        .o_pixel_value   (o_pixel_value),
        .o_bad_operand   (o_bad_operand)
    );

    always #1 i_clk = ~i_clk;

    // Frame predictor
    function automatic bit on_frame(int x, int y);
        return x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H;
    endfunction

    function automatic void plot_pixel(int x, int y);
        if (on_frame(x, y)) begin
            frame_bits[y][x] = 1'b1;
            last_px = x;
            last_py = y;
        end
    endfunction

    // Bresenham walk; the end pixel itself is never set
    function automatic void trace_line(int ax, int ay, int bx, int by);
        int adx, ady, stepx, stepy, dneg, acc, twice;
        adx   = bx > ax ? bx - ax : ax - bx;
        ady   = by > ay ? by - ay : ay - by;
        stepx = ax < bx ? 1 : -1;
        stepy = ay < by ? 1 : -1;
        dneg  = -ady;
        acc   = adx + dneg;
        while (!(ax == bx && ay == by)) begin
            plot_pixel(ax, ay);
            twice = 2 * acc;
            if (twice >= dneg) begin
                acc += dneg;
                ax  += stepx;
            end
            if (twice <= adx) begin
                acc += adx;
                ay  += stepy;
            end
        end
    endfunction

    // Plot all eight octant mirrors, horizontal offsets doubled
    function automatic void plot_octants(int cx, int cy, int u, int v);
        plot_pixel(cx + u * 2, cy + v);
        plot_pixel(cx - u * 2, cy + v);
        plot_pixel(cx + u * 2, cy - v);
        plot_pixel(cx - u * 2, cy - v);
        plot_pixel(cx + v * 2, cy + u);
        plot_pixel(cx - v * 2, cy + u);
        plot_pixel(cx + v * 2, cy - u);
        plot_pixel(cx - v * 2, cy - u);
    endfunction

    function automatic void trace_circle(int cx, int cy, int r);
        int u, v, decide;
        u      = 0;
        v      = r;
        decide = 1 - r;
        plot_octants(cx, cy, u, v);
        while (v > u) begin
            u++;
            if (decide < 0) begin
                decide += 2 * u + 1;
            end else begin
                v--;
                decide += 2 * (u - v) + 1;
            end
            plot_octants(cx, cy, u, v);
        end
    endfunction

    // Apply one command to the predicted frame and return the result it owes
    function automatic t_draw_result apply_draw_cmd(t_draw_cmd c);
        t_draw_result r;
        int fx, fy, sx, sy, rad;
        fx  = int'(c.fx);
        fy  = int'(c.fy);
        sx  = int'(c.sx);
        sy  = int'(c.sy);
        rad = int'(c.rad);
        r   = '{pixel: 1'b0, bad: 1'b0};
        case (c.cmd)
            CMD_CLEAR: begin
                cnt_clear++;
                foreach (frame_bits[y, x]) frame_bits[y][x] = 1'b0;
            end
            CMD_LINE: begin
                cnt_line++;
                if (on_frame(fx, fy) && on_frame(sx, sy)) trace_line(fx, fy, sx, sy);
                else r.bad = 1'b1;
            end
            CMD_CIRCLE: begin
                cnt_circle++;
                if (on_frame(fx, fy) && rad <= FRAME_W && rad <= FRAME_H)
                    trace_circle(fx, fy, rad);
                else
                    r.bad = 1'b1;
            end
            default: begin
                cnt_read++;
                if (on_frame(fx, fy)) r.pixel = frame_bits[fy][fx];
                else r.bad = 1'b1;
                if (r.pixel) cnt_read_set++;
            end
        endcase
        if (r.bad) cnt_bad++;
        return r;
    endfunction

    // Append one directed table row
    function automatic void add_row(logic [CMD_W-1:0] cmd, int fx, int fy, int sx, int sy,
                                    int rad, bit typed, bit pixel, bit bad);
        t_plan_row row;
        row.c     = '{cmd: cmd, fx: X_W'(fx), fy: Y_W'(fy), sx: X_W'(sx), sy: Y_W'(sy),
                      rad: R_W'(rad)};
        row.typed = typed;
        row.res   = '{pixel: pixel, bad: bad};
        plan      = {plan, row};
    endfunction

    // Mostly legal coordinates, a few past the frame edge
    function automatic int pick_x();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(FRAME_W, 127)
                                            : $urandom_range(0, FRAME_W - 1);
    endfunction

    function automatic int pick_y();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(FRAME_H, 63)
                                            : $urandom_range(0, FRAME_H - 1);
    endfunction

    // Random command; unused fields carry noise
    function automatic t_draw_cmd random_draw_cmd();
        t_draw_cmd c;
        int pick, x, y;
        pick  = $urandom_range(0, 199);
        c.fx  = X_W'($urandom_range(0, 127));
        c.fy  = Y_W'($urandom_range(0, 63));
        c.sx  = X_W'($urandom_range(0, 127));
        c.sy  = Y_W'($urandom_range(0, 63));
        c.rad = R_W'($urandom_range(0, 63));
        if (pick < 3) begin
            c.cmd = CMD_CLEAR;
        end else if (pick < 83) begin
            c.cmd = CMD_LINE;
            c.fx  = X_W'(pick_x());
            c.fy  = Y_W'(pick_y());
            c.sx  = X_W'(pick_x());
            c.sy  = Y_W'(pick_y());
        end else if (pick < 133) begin
            c.cmd = CMD_CIRCLE;
            c.fx  = X_W'(pick_x());
            c.fy  = Y_W'(pick_y());
            case ($urandom_range(0, 19))
                0:             c.rad = R_W'($urandom_range(FRAME_H + 1, 63));
                1, 2, 3, 4, 5: c.rad = R_W'($urandom_range(0, FRAME_H));
                default:       c.rad = R_W'($urandom_range(0, 10));
            endcase
        end else begin
            c.cmd = CMD_READ;
            if ($urandom_range(0, 1) == 0) begin
                // Probe around the latest plotted pixel so reads often hit set bits
                x = last_px + int'($urandom_range(0, 2)) - 1;
                y = last_py + int'($urandom_range(0, 2)) - 1;
                c.fx = X_W'(x < 0 ? 0 : x);
                c.fy = Y_W'(y < 0 ? 0 : y);
            end else begin
                c.fx = X_W'(pick_x());
                c.fy = Y_W'(pick_y());
            end
        end
        return c;
    endfunction

    // Drive one command beat and hold it until the block takes it
    task automatic send_draw_cmd(t_draw_cmd c, bit typed, t_draw_result typed_res);
        t_draw_result r;
        start           <= 1'b1;
        i_command       <= c.cmd;
        i_first_x       <= c.fx;
        i_first_y       <= c.fy;
        i_second_x      <= c.sx;
        i_second_y      <= c.sy;
        i_circle_radius <= c.rad;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = apply_draw_cmd(c);
        owed_results = {owed_results, (typed ? typed_res : r)};
    endtask

    task automatic idle_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_draw_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
                $error("result beat with no command outstanding");
                err_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_pixel_value !== want.pixel) begin
                    $error("pixel_value: expected %0b, got %0b", want.pixel, o_pixel_value);
                    err_count++;
                end
                if (o_bad_operand !== want.bad) begin
                    $error("bad_operand: expected %0b, got %0b", want.bad, o_bad_operand);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_draw_result no_res;
        int burst;
        no_res  = '{pixel: 1'b0, bad: 1'b0};
        last_px = 0;
        last_py = 0;
        foreach (frame_bits[y, x]) frame_bits[y][x] = 1'b0;

        // Extremes, every command and each corner case
        add_row(CMD_READ,    0,  0,  0,  0,  0, TYPED,      0, 0);
        add_row(CMD_READ,   79, 39,  0,  0,  0, TYPED,      0, 0);
        add_row(CMD_READ,   80,  0,  0,  0,  0, TYPED,      0, 1);
        add_row(CMD_READ,    0, 40,  0,  0,  0, TYPED,      0, 1);
        add_row(CMD_READ,  127, 63,  0,  0,  0, TYPED,      0, 1);
        add_row(CMD_LINE,    0,  0, 79, 39,  0, TYPED,      0, 0);
        add_row(CMD_READ,    0,  0,  0,  0,  0, FROM_MODEL, 0, 0);
        add_row(CMD_READ,   79, 39,  0,  0,  0, FROM_MODEL, 0, 0);
        add_row(CMD_LINE,    5, 30,  5, 30,  0, TYPED,      0, 0);
        add_row(CMD_READ,    5, 30,  0,  0,  0, FROM_MODEL, 0, 0);
        add_row(CMD_LINE,   80,  0,  0,  0,  0, TYPED,      0, 1);
        add_row(CMD_LINE,    0,  0,  0, 40,  0, TYPED,      0, 1);
        add_row(CMD_LINE,  127, 63,127, 63,  0, TYPED,      0, 1);
        add_row(CMD_LINE,   79,  0,  0, 39,  0, TYPED,      0, 0);
        add_row(CMD_LINE,   10,  0, 12, 39,  0, TYPED,      0, 0);
        add_row(CMD_LINE,    0, 20, 79, 20,  0, TYPED,      0, 0);
        add_row(CMD_CIRCLE, 40, 25,  0,  0,  0, TYPED,      0, 0);
        add_row(CMD_READ,   40, 25,  0,  0,  0, FROM_MODEL, 0, 0);
        add_row(CMD_CIRCLE, 40, 20,  0,  0, 40, TYPED,      0, 0);
        add_row(CMD_CIRCLE, 40, 20,  0,  0, 41, TYPED,      0, 1);
        add_row(CMD_CIRCLE, 80, 20,  0,  0,  5, TYPED,      0, 1);
        add_row(CMD_CIRCLE,  2,  2,  0,  0, 10, TYPED,      0, 0);
        add_row(CMD_READ,   22,  2,  0,  0,  0, FROM_MODEL, 0, 0);
        add_row(CMD_CLEAR,   0,  0,  0,  0,  0, TYPED,      0, 0);
        add_row(CMD_READ,    0,  0,  0,  0,  0, TYPED,      0, 0);

        // Hold reset, then release it; the first beat waits until the block is idle
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) send_draw_cmd(plan[i].c, plan[i].typed, plan[i].res);

        // Random bursts with gaps; long bursts leave stretches without idling
        burst = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
                wait_results_drained();
            end else if (burst == 0) begin
                idle_sender($urandom_range(1, 24));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            end
            send_draw_cmd(random_draw_cmd(), FROM_MODEL, no_res);
            if (burst > 0) burst--;
        end

        wait_results_drained();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d clears, %0d lines, %0d circles and %0d reads (%0d hit a set pixel).",
                 cnt_clear, cnt_line, cnt_circle, cnt_read, cnt_read_set);
        $display("%0d commands were rejected for out-of-range operands.", cnt_bad);
        if (err_count == 0 && owed_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lcfr_pkg.sv
rtl/line_circle_frame_rasterizer_top.sv
sim/tb_line_circle_frame_rasterizer_top.sv
